// File: rtl/device_presence_table_with_aging_defines.svh
// ----------------------------------------------------------------------------
// Device presence table assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef DEVICE_PRESENCE_TABLE_WITH_AGING_DEFINES_SVH
`define DEVICE_PRESENCE_TABLE_WITH_AGING_DEFINES_SVH

// Property must hold at every clock edge out of reset.
`define DPT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be true out of reset.
`define DPT_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/dpt_pkg.sv
// ----------------------------------------------------------------------------
// Device presence table package
// Sizes, field widths, codes and shared types of the presence table.
// ----------------------------------------------------------------------------
`default_nettype none

package dpt_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned AllSlots   = 2 * TableDepth;
  localparam int unsigned AddrW      = $clog2(AllSlots);
  localparam int unsigned SIdxW      = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);

  localparam int unsigned IdW     = 16;
  localparam int unsigned TtlW    = 8;
  localparam int unsigned ActW    = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned SlotW   = 6;
  localparam int unsigned LiveW   = 7;
  localparam int unsigned ClassW  = 2;
  localparam int unsigned PAddrW  = 3;
  localparam int unsigned PDataW  = 32;
  localparam int unsigned RegIdxW = PAddrW - 2;

  localparam logic [TtlW-1:0] TtlReset  = TtlW'(2);
  localparam logic [ActW-1:0] ActiveMax = '1;

  localparam logic KIND_ANNOUNCE = 1'b0;
  localparam logic KIND_TICK     = 1'b1;

  localparam logic [ClassW-1:0] CLASS_SENSOR   = 2'd0;
  localparam logic [ClassW-1:0] CLASS_ACTUATOR = 2'd1;

  localparam logic [RegIdxW-1:0] REG_TTL_RELOAD = '0;

  typedef enum logic [StatusW-1:0] {
    STATUS_INSERTED  = 3'd0,
    STATUS_REFRESHED = 3'd1,
    STATUS_FULL      = 3'd2,
    STATUS_UNKNOWN   = 3'd3,
    STATUS_TICK      = 3'd4
  } status_e;

  typedef struct packed {
    logic            used;
    logic [IdW-1:0]  id;
    logic [TtlW-1:0] ttl;
    logic [ActW-1:0] active;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    entry_t           wr_data;
  } ram_req_t;

  typedef struct packed {
    status_e          status;
    logic [SlotW-1:0] slot;
    logic [ActW-1:0]  active;
    logic [LiveW-1:0] live_s;
    logic [LiveW-1:0] live_a;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/device_presence_table_with_aging.sv
// ----------------------------------------------------------------------------
// Device presence table with aging
// Sensor and actuator id tables with TTL aging, APB reload register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one beat per item: an
//   announce (kind 0) with class and id, or a tick (kind 1). Every item
//   yields exactly one result beat on the output channel
//   (out_valid_o/out_ready_i) with status, slot, count and live counts.
//   Both tables share one entry memory; the sequencer touches one entry
//   per cycle, reading the next entry while writing back the current one.
//   An announce scans its table from slot 0 up to the first matching or free
//   slot, or through the whole table when it is full; an unknown class is
//   answered without a scan, and a tick walks both tables. A new item is
//   accepted the cycle after the result is loaded into the output register.
//   Reset empties both tables through per-entry valid bits (no sweep) and
//   sets ttl_reload to 2. A stalled receiver holds the result in the
//   output register; the sequencer finishes the next item and waits.
//   Write ttl_reload (offset 0) only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module device_presence_table_with_aging (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [dpt_pkg::PAddrW-1:0]   paddr,
  input  wire logic [dpt_pkg::PDataW-1:0]   pwdata,
  output logic [dpt_pkg::PDataW-1:0]        prdata,
  output logic                              pready,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         kind_i,
  input  wire logic [dpt_pkg::ClassW-1:0]   device_class_i,
  input  wire logic [dpt_pkg::IdW-1:0]      device_id_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [dpt_pkg::StatusW-1:0]       status_o,
  output logic [dpt_pkg::SlotW-1:0]         slot_o,
  output logic [dpt_pkg::ActW-1:0]          active_ticks_o,
  output logic [dpt_pkg::LiveW-1:0]         live_sensors_o,
  output logic [dpt_pkg::LiveW-1:0]         live_actuators_o
);

  logic [dpt_pkg::TtlW-1:0] ttl_q;
  logic                     ttl_sel;
  logic                     out_valid_q;
  dpt_pkg::result_t         out_q;
  dpt_pkg::ram_req_t        ram_req;
  dpt_pkg::entry_t          ram_rd;
  dpt_pkg::result_t         res;
  logic                     res_valid;
  logic                     res_ready;

  // config register
  assign ttl_sel = (paddr[dpt_pkg::PAddrW-1:2] == dpt_pkg::REG_TTL_RELOAD);
  assign pready  = 1'b1;
  assign prdata  = ttl_sel ? dpt_pkg::PDataW'(ttl_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q <= dpt_pkg::TtlReset;
    end else if (psel && penable && pwrite && ttl_sel) begin
      ttl_q <= pwdata[dpt_pkg::TtlW-1:0];
    end
  end

  dpt_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ram_req),
    .rd_data_o (ram_rd)
  );

  dpt_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .device_class_i (device_class_i),
    .device_id_i    (device_id_i),
    .ttl_reload_i   (ttl_q),
    .ram_req_o      (ram_req),
    .ram_rd_i       (ram_rd),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  // output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign slot_o           = out_q.slot;
  assign active_ticks_o   = out_q.active;
  assign live_sensors_o   = out_q.live_s;
  assign live_actuators_o = out_q.live_a;

endmodule

`default_nettype wire

// File: rtl/dpt_ram.sv
// ----------------------------------------------------------------------------
// Device presence table entry memory
// One write and one read port, registered read data; per-entry valid bits
// make unwritten entries read as empty.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt_ram (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dpt_pkg::ram_req_t req_i,
  output dpt_pkg::entry_t        rd_data_o
);

  dpt_pkg::entry_t                  mem_q [dpt_pkg::AllSlots];
  dpt_pkg::entry_t                  rd_q;
  logic [dpt_pkg::AllSlots-1:0]     vld_q;
  logic                             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

// File: rtl/dpt_ctrl.sv
// ----------------------------------------------------------------------------
// Device presence table sequencer
// Walks the entry memory one entry per cycle: slot search on announce,
// aging pass with live counts on tick. Reads run one entry ahead of the
// write-back, so no entry is read and written in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         kind_i,
  input  wire logic [dpt_pkg::ClassW-1:0]   device_class_i,
  input  wire logic [dpt_pkg::IdW-1:0]      device_id_i,
  input  wire logic [dpt_pkg::TtlW-1:0]     ttl_reload_i,
  output dpt_pkg::ram_req_t                 ram_req_o,
  input  wire dpt_pkg::entry_t              ram_rd_i,
  output logic                              res_valid_o,
  input  wire logic                         res_ready_i,
  output dpt_pkg::result_t                  res_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  localparam logic [dpt_pkg::AddrW-1:0] ActBase  = dpt_pkg::AddrW'(dpt_pkg::TableDepth);
  localparam logic [dpt_pkg::AddrW-1:0] TickLast = dpt_pkg::AddrW'(dpt_pkg::AllSlots - 1);
  localparam logic [dpt_pkg::AddrW-1:0] TblSpan  = dpt_pkg::AddrW'(dpt_pkg::TableDepth - 1);

  logic [1:0]                   state_q, state_d;
  logic                         kind_q, kind_d;
  logic [dpt_pkg::IdW-1:0]      id_q, id_d;
  logic [dpt_pkg::AddrW-1:0]    addr_q, addr_d;
  logic [dpt_pkg::AddrW-1:0]    base_q, base_d;
  logic [dpt_pkg::AddrW-1:0]    last_q, last_d;
  logic [dpt_pkg::CntW-1:0]     live_s_q, live_s_d;
  logic [dpt_pkg::CntW-1:0]     live_a_q, live_a_d;
  dpt_pkg::result_t             res_q, res_d;

  dpt_pkg::entry_t              ent;
  logic [dpt_pkg::TtlW-1:0]     ttl_dec;
  logic [dpt_pkg::SIdxW-1:0]    slot_loc;
  logic [dpt_pkg::AddrW-1:0]    start_addr;
  logic [dpt_pkg::ActW-1:0]     act_inc;

  assign ent      = ram_rd_i;
  assign ttl_dec  = (ent.ttl != '0) ? ent.ttl - 1'b1 : '0;
  assign slot_loc = dpt_pkg::SIdxW'(addr_q - base_q);
  assign act_inc  = (ent.active != dpt_pkg::ActiveMax) ? ent.active + 1'b1 : ent.active;
  assign start_addr = (kind_i == dpt_pkg::KIND_TICK || device_class_i == dpt_pkg::CLASS_SENSOR)
                      ? '0 : ActBase;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_RESP);
  assign res_o       = res_q;

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    id_d      = id_q;
    addr_d    = addr_q;
    base_d    = base_q;
    last_d    = last_q;
    live_s_d  = live_s_q;
    live_a_d  = live_a_q;
    res_d     = res_q;
    ram_req_o = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d   = kind_i;
          id_d     = device_id_i;
          live_s_d = '0;
          live_a_d = '0;
          addr_d   = start_addr;
          base_d   = start_addr;
          last_d   = (kind_i == dpt_pkg::KIND_TICK) ? TickLast : start_addr + TblSpan;
          if (kind_i == dpt_pkg::KIND_ANNOUNCE && device_class_i != dpt_pkg::CLASS_SENSOR &&
              device_class_i != dpt_pkg::CLASS_ACTUATOR) begin
            res_d   = '0;
            res_d.status = dpt_pkg::STATUS_UNKNOWN;
            state_d = ST_RESP;
          end else begin
            ram_req_o.rd_en   = 1'b1;
            ram_req_o.rd_addr = start_addr;
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        ram_req_o.wr_addr = addr_q;
        ram_req_o.rd_addr = addr_q + 1'b1;
        if (kind_q == dpt_pkg::KIND_TICK) begin
          ram_req_o.wr_en       = 1'b1;
          ram_req_o.wr_data     = ent;
          ram_req_o.wr_data.ttl = ttl_dec;
          if (ttl_dec == '0) begin
            ram_req_o.wr_data.active = '0;
          end else if (ent.used) begin
            if (addr_q < ActBase) begin
              live_s_d = live_s_q + 1'b1;
            end else begin
              live_a_d = live_a_q + 1'b1;
            end
          end
          if (addr_q == last_q) begin
            res_d        = '0;
            res_d.status = dpt_pkg::STATUS_TICK;
            res_d.live_s = dpt_pkg::LiveW'(live_s_d);
            res_d.live_a = dpt_pkg::LiveW'(live_a_d);
            state_d      = ST_RESP;
          end else begin
            ram_req_o.rd_en = 1'b1;
            addr_d = addr_q + 1'b1;
          end
        end else if (!ent.used) begin
          ram_req_o.wr_en   = 1'b1;
          ram_req_o.wr_data = '{used: 1'b1, id: id_q, ttl: ttl_reload_i, active: ent.active};
          res_d        = '0;
          res_d.status = dpt_pkg::STATUS_INSERTED;
          res_d.slot   = dpt_pkg::SlotW'(slot_loc);
          res_d.active = ent.active;
          state_d      = ST_RESP;
        end else if (ent.id == id_q) begin
          ram_req_o.wr_en   = 1'b1;
          ram_req_o.wr_data = '{used: 1'b1, id: id_q, ttl: ttl_reload_i, active: act_inc};
          res_d        = '0;
          res_d.status = dpt_pkg::STATUS_REFRESHED;
          res_d.slot   = dpt_pkg::SlotW'(slot_loc);
          res_d.active = act_inc;
          state_d      = ST_RESP;
        end else if (addr_q == last_q) begin
          res_d        = '0;
          res_d.status = dpt_pkg::STATUS_FULL;
          state_d      = ST_RESP;
        end else begin
          ram_req_o.rd_en = 1'b1;
          addr_d = addr_q + 1'b1;
        end
      end

      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    id_q     <= id_d;
    addr_q   <= addr_d;
    base_q   <= base_d;
    last_q   <= last_d;
    live_s_q <= live_s_d;
    live_a_q <= live_a_d;
    res_q    <= res_d;
  end

endmodule

`default_nettype wire

// File: rtl/dpt_checker.sv
// ----------------------------------------------------------------------------
// Device presence table port checker
// Result channel checks on the top level ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "device_presence_table_with_aging_defines.svh"

module dpt_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [dpt_pkg::StatusW-1:0]  status_o,
  input wire logic [dpt_pkg::SlotW-1:0]    slot_o,
  input wire logic [dpt_pkg::ActW-1:0]     active_ticks_o,
  input wire logic [dpt_pkg::LiveW-1:0]    live_sensors_o,
  input wire logic [dpt_pkg::LiveW-1:0]    live_actuators_o
);

  `DPT_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(slot_o) && $stable(active_ticks_o), "result beat changed while stalled")
  `DPT_ASSERT_NEVER(a_status_code, out_valid_o && status_o > dpt_pkg::STATUS_TICK, "undefined status code")
  `DPT_ASSERT(a_live_announce, out_valid_o && status_o != dpt_pkg::STATUS_TICK |-> live_sensors_o == '0 && live_actuators_o == '0, "live counts on announce")
  `DPT_ASSERT(a_no_slot, out_valid_o && (status_o == dpt_pkg::STATUS_FULL || status_o == dpt_pkg::STATUS_UNKNOWN || status_o == dpt_pkg::STATUS_TICK) |-> slot_o == '0 && active_ticks_o == '0, "slot or count without entry")

endmodule

bind device_presence_table_with_aging dpt_checker u_dpt_checker (.*);

`default_nettype wire

// File: dv/device_presence_table_with_aging_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Device presence table checker
// Watches the APB port and both item channels. It keeps its own copy of the
// sensor and actuator tables and of the reload register, predicts one result
// per accepted input beat, and compares each output beat with the oldest
// prediction. APB reads of the reload register are checked as well.
// ----------------------------------------------------------------------------

module device_presence_table_with_aging_checker
  import dpt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PAddrW-1:0]   paddr,
  input  logic [PDataW-1:0]   pwdata,
  input  logic [PDataW-1:0]   prdata,
  input  logic                pready,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                kind_i,
  input  logic [ClassW-1:0]   device_class_i,
  input  logic [IdW-1:0]      device_id_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [StatusW-1:0]  status_i,
  input  logic [SlotW-1:0]    slot_i,
  input  logic [ActW-1:0]     active_ticks_i,
  input  logic [LiveW-1:0]    live_sensors_i,
  input  logic [LiveW-1:0]    live_actuators_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  results_o,
  output int                  full_hits_o,
  output int                  saturated_o
);

  logic            slot_used  [AllSlots];
  logic [IdW-1:0]  slot_id    [AllSlots];
  logic [TtlW-1:0] slot_ttl   [AllSlots];
  logic [ActW-1:0] slot_count [AllSlots];
  logic [TtlW-1:0] reload_ticks;

  result_t outcome_q [$];
  int      mismatches;
  int      pending;
  int      results;
  int      full_hits;
  int      saturated;

  assign fail_count_o = mismatches;
  assign pending_o    = pending;
  assign results_o    = results;
  assign full_hits_o  = full_hits;
  assign saturated_o  = saturated;

  function automatic result_t table_outcome(input logic            kind,
                                            input logic [ClassW-1:0] cls,
                                            input logic [IdW-1:0]    id);
    result_t r;
    int      live_s;
    int      live_a;
    int      base;
    int      s;
    r      = '0;
    live_s = 0;
    live_a = 0;
    if (kind == KIND_TICK) begin
      for (s = 0; s < AllSlots; s++) begin
        if (slot_ttl[s] != '0) slot_ttl[s] = slot_ttl[s] - 1'b1;
        if (slot_ttl[s] == '0) begin
          slot_count[s] = '0;
        end else if (slot_used[s]) begin
          if (s < TableDepth) live_s++;
          else live_a++;
        end
      end
      r.status = STATUS_TICK;
      r.live_s = LiveW'(live_s);
      r.live_a = LiveW'(live_a);
      return r;
    end
    if (cls != CLASS_SENSOR && cls != CLASS_ACTUATOR) begin
      r.status = STATUS_UNKNOWN;
      return r;
    end
    base = (cls == CLASS_ACTUATOR) ? TableDepth : 0;
    for (s = 0; s < TableDepth; s++) begin
      if (!slot_used[base + s]) begin
        slot_used[base + s] = 1'b1;
        slot_id[base + s]   = id;
        slot_ttl[base + s]  = reload_ticks;
        r.status = STATUS_INSERTED;
        r.slot   = SlotW'(s);
        r.active = slot_count[base + s];
        return r;
      end
      if (slot_id[base + s] == id) begin
        if (slot_count[base + s] != ActiveMax) slot_count[base + s] = slot_count[base + s] + 1'b1;
        slot_ttl[base + s] = reload_ticks;
        r.status = STATUS_REFRESHED;
        r.slot   = SlotW'(s);
        r.active = slot_count[base + s];
        return r;
      end
    end
    r.status = STATUS_FULL;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      for (int i = 0; i < AllSlots; i++) begin
        slot_used[i]  = 1'b0;
        slot_id[i]    = '0;
        slot_ttl[i]   = '0;
        slot_count[i] = '0;
      end
      reload_ticks = TtlReset;
      outcome_q.delete();
      mismatches = 0;
      results    = 0;
      full_hits  = 0;
      saturated  = 0;
      pending   <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results++;
        got.status = status_e'(status_i);
        got.slot   = slot_i;
        got.active = active_ticks_i;
        got.live_s = live_sensors_i;
        got.live_a = live_actuators_i;
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: status %0d slot %0d active %0d live %0d/%0d",
                     got.status, got.slot, got.active, got.live_s, got.live_a);
        end else begin
          want = outcome_q.pop_front();
          if (want.status == STATUS_FULL) full_hits++;
          if (want.status == STATUS_REFRESHED && want.active == ActiveMax) saturated++;
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result %0d mismatch: expected status %0d slot %0d active %0d ",
                        "live %0d/%0d, got status %0d slot %0d active %0d live %0d/%0d"},
                       results, want.status, want.slot, want.active, want.live_s,
                       want.live_a, got.status, got.slot, got.active, got.live_s,
                       got.live_a);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        outcome_q.push_back(table_outcome(kind_i, device_class_i, device_id_i));
      if (psel && penable && pready && paddr[PAddrW-1:2] == REG_TTL_RELOAD) begin
        if (pwrite) begin
          reload_ticks = pwdata[TtlW-1:0];
        end else if (prdata != PDataW'(reload_ticks)) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ttl_reload read mismatch: expected %0d, got %0d", reload_ticks, prdata);
        end
      end
      pending <= outcome_q.size();
    end
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Device presence table testbench
// Drives announce and tick beats and APB writes of the reload register into
// the presence table, with random gaps on both channels, a long output stall
// and a repeated-refresh run. Checking is done by the checker instance.
// ----------------------------------------------------------------------------

module testbench;
  import dpt_pkg::*;

  localparam int unsigned       CycleLimit     = 2_000_000;
  localparam int unsigned       LongHold       = 400;
  localparam int unsigned       PoolSize       = 72;
  localparam int unsigned       RepeatBeats    = 24;
  localparam logic [RegIdxW-1:0] REG_SPARE      = 1'b1;
  localparam logic [ClassW-1:0]  CLASS_OTHER    = 2'd2;
  localparam logic [ClassW-1:0]  CLASS_RESERVED = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PAddrW-1:0]   paddr;
  logic [PDataW-1:0]   pwdata;
  logic [PDataW-1:0]   prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                kind_i;
  logic [ClassW-1:0]   device_class_i;
  logic [IdW-1:0]      device_id_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [StatusW-1:0]  status_o;
  logic [SlotW-1:0]    slot_o;
  logic [ActW-1:0]     active_ticks_o;
  logic [LiveW-1:0]    live_sensors_o;
  logic [LiveW-1:0]    live_actuators_o;

  int          fail_count;
  int          pending;
  int          results;
  int          full_hits;
  int          saturated;
  int          tx_idle_pct;
  int          rx_idle_pct;
  logic        hold_go;
  int          hold_cnt;
  int unsigned cycles;
  logic [IdW-1:0] id_pool [2][PoolSize];

  device_presence_table_with_aging uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .device_class_i   (device_class_i),
    .device_id_i      (device_id_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .slot_o           (slot_o),
    .active_ticks_o   (active_ticks_o),
    .live_sensors_o   (live_sensors_o),
    .live_actuators_o (live_actuators_o)
  );

  device_presence_table_with_aging_checker table_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .kind_i           (kind_i),
    .device_class_i   (device_class_i),
    .device_id_i      (device_id_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_i         (status_o),
    .slot_i           (slot_o),
    .active_ticks_i   (active_ticks_o),
    .live_sensors_i   (live_sensors_o),
    .live_actuators_i (live_actuators_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .results_o        (results),
    .full_hits_o      (full_hits),
    .saturated_o      (saturated)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("device_presence_table_with_aging test failed");
      $finish;
    end
  end

  // result side: random gaps, plus one long counted stall
  always @(posedge clk_i) begin
    if (hold_go && hold_cnt < LongHold) begin
      out_ready_i <= 1'b0;
      hold_cnt    <= hold_cnt + 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic logic [PAddrW-1:0] reg_addr(input logic [RegIdxW-1:0] idx);
    return {idx, 2'b00};
  endfunction

  task automatic apb_access(input logic wr, input logic [RegIdxW-1:0] idx,
                            input logic [PDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= reg_addr(idx);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_beat(input logic k, input logic [ClassW-1:0] cls,
                           input logic [IdW-1:0] id);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= k;
    device_class_i <= cls;
    device_id_i    <= id;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_random(input int beats, input int hold_at);
    int r;
    int ci;
    for (int i = 0; i < beats; i++) begin
      if (i == hold_at) hold_go <= 1'b1;
      r  = $urandom_range(99);
      ci = $urandom_range(1);
      if (r < 14)
        send_beat(KIND_TICK, ClassW'($urandom_range(3)), IdW'($urandom));
      else if (r < 19)
        send_beat(KIND_ANNOUNCE, ClassW'($urandom_range(CLASS_OTHER, CLASS_RESERVED)),
                  IdW'($urandom));
      else if (r < 80)
        send_beat(KIND_ANNOUNCE, ci ? CLASS_ACTUATOR : CLASS_SENSOR,
                  id_pool[ci][$urandom_range(PoolSize - 1)]);
      else
        send_beat(KIND_ANNOUNCE, ci ? CLASS_ACTUATOR : CLASS_SENSOR, IdW'($urandom));
    end
  endtask

  initial begin
    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_valid_i     <= 1'b0;
    kind_i         <= KIND_ANNOUNCE;
    device_class_i <= CLASS_SENSOR;
    device_id_i    <= '0;
    hold_go        <= 1'b0;
    rx_idle_pct    <= 0;
    tx_idle_pct     = 0;
    for (int c = 0; c < 2; c++)
      for (int i = 0; i < PoolSize; i++) id_pool[c][i] = IdW'($urandom);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset reload of 2, id extremes, unknown classes, expiry
    apb_access(1'b0, REG_TTL_RELOAD, '0);
    send_beat(KIND_ANNOUNCE, CLASS_SENSOR, 16'h0000);
    send_beat(KIND_ANNOUNCE, CLASS_SENSOR, 16'hFFFF);
    send_beat(KIND_ANNOUNCE, CLASS_SENSOR, 16'h0000);
    send_beat(KIND_ANNOUNCE, CLASS_ACTUATOR, 16'hFFFF);
    send_beat(KIND_ANNOUNCE, CLASS_ACTUATOR, 16'h5A5A);
    send_beat(KIND_ANNOUNCE, CLASS_ACTUATOR, 16'hA5A5);
    send_beat(KIND_ANNOUNCE, CLASS_OTHER, 16'h1234);
    send_beat(KIND_ANNOUNCE, CLASS_RESERVED, 16'hFFFF);
    send_beat(KIND_TICK, CLASS_RESERVED, 16'hFFFF);
    send_beat(KIND_TICK, CLASS_SENSOR, 16'h0000);
    send_beat(KIND_ANNOUNCE, CLASS_SENSOR, 16'h0000);
    send_beat(KIND_TICK, CLASS_ACTUATOR, 16'hA5A5);
    drain();
    apb_access(1'b1, REG_TTL_RELOAD, '0);
    apb_access(1'b0, REG_TTL_RELOAD, '0);
    send_beat(KIND_ANNOUNCE, CLASS_SENSOR, 16'hFFFF);
    send_beat(KIND_TICK, CLASS_SENSOR, 16'h0000);
    send_beat(KIND_ANNOUNCE, CLASS_SENSOR, 16'hFFFF);
    drain();
    apb_access(1'b1, REG_SPARE, 32'hFFFF_FFFF);
    apb_access(1'b0, REG_TTL_RELOAD, '0);
    apb_access(1'b1, REG_TTL_RELOAD, 32'hFFFF_FF01);
    apb_access(1'b0, REG_TTL_RELOAD, '0);
    send_beat(KIND_ANNOUNCE, CLASS_ACTUATOR, 16'h5A5A);
    send_beat(KIND_TICK, CLASS_OTHER, 16'h0F0F);
    drain();

    // random: long-lived entries, output stall partway through
    apb_access(1'b1, REG_TTL_RELOAD, 32'd255);
    tx_idle_pct  = 9;
    rx_idle_pct <= 78;
    run_random(150, 40);
    drain();

    apb_access(1'b1, REG_TTL_RELOAD, 32'd1);
    tx_idle_pct  = 78;
    rx_idle_pct <= 9;
    run_random(60, -1);
    drain();
    apb_access(1'b1, REG_TTL_RELOAD, PDataW'($urandom_range(3, 20)));
    run_random(90, -1);
    drain();

    apb_access(1'b1, REG_TTL_RELOAD, PDataW'($urandom_range(2, 254)));
    tx_idle_pct  = 0;
    rx_idle_pct <= 0;
    run_random(100, -1);
    drain();

    // back-to-back refreshes of the slot 0 sensor
    apb_access(1'b1, REG_TTL_RELOAD, 32'd255);
    apb_access(1'b0, REG_TTL_RELOAD, '0);
    for (int i = 0; i < RepeatBeats; i++)
      send_beat(KIND_ANNOUNCE, CLASS_SENSOR, 16'h0000);
    send_beat(KIND_TICK, CLASS_SENSOR, 16'h0000);
    drain();
    repeat (2 * TableDepth + 8) @(posedge clk_i);

    $display("checked %0d result beats, %0d table-full answers, %0d saturated counts",
             results, full_hits, saturated);
    $display("reloads 0, 1, 255 and random; gaps on both sides, %0d-cycle output stall",
             LongHold);
    if (fail_count == 0)
      $display("device_presence_table_with_aging test passed");
    else
      $display("device_presence_table_with_aging test failed");
    $finish;
  end

endmodule
